### rtl/particle_pair_neighbor_table_macros.svh
// Assertion macros for the particle pair neighbor table RTL.
`ifndef PARTICLE_PAIR_NEIGHBOR_TABLE_MACROS_SVH
`define PARTICLE_PAIR_NEIGHBOR_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define PPNT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppnt assertion failed");
// Clocked check that also holds during reset.
`define PPNT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ppnt assertion failed");
`else
`define PPNT_ASSERT(lbl, clk, rst_n, prop)
`define PPNT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/ppnt_pkg.sv
// Shared types and constants of the particle pair neighbor table.
`default_nettype none
package ppnt_pkg;

  // Default sizes
  localparam int PARTICLES_DEF = 1024;
  localparam int ROW_SLOTS_DEF = 64;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int PART_W   = 10;
  localparam int SLOT_W   = 6;
  localparam int NB_W     = 10;
  localparam int REF_W    = 15;
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = 16;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  // Pair numbers must fit in REF_W bits
  localparam logic [TOTAL_W-1:0] PAIR_REF_LIMIT = TOTAL_W'(32768);

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_SELF = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_LO,
    S_HI,
    S_WR_HI,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [NB_W-1:0]    neighbor;
    logic [REF_W-1:0]   pair_ref;
    logic [COUNT_W-1:0] higher_count;
    logic [COUNT_W-1:0] lower_count;
    logic [TOTAL_W-1:0] pair_total;
    status_t            status;
  } result_t;

endpackage
`default_nettype wire

### rtl/ppnt_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module ppnt_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 14
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/particle_pair_neighbor_table.sv
// Particle pair neighbor table: builds per-particle neighbor rows from pair transactions.
//
// One transaction is taken at a time. The per-particle front/back counts live in
// a PARTICLES-deep RAM and the rows in a PARTICLES*ROW_SLOTS-deep RAM, both with
// one write and one read port and registered read data. A no-op goes from idle
// straight to S_FINISH, a read or a rejected insert passes through S_LO and S_HI,
// and an accepted insert also through S_WR_HI (two count reads and two
// read-modify-write passes through the single count write port). A clear writes
// every count entry once. After reset the same clearing pass runs before
// in_tready first rises. A finished result waits in the output register, so the
// next transaction can be taken while it is still unclaimed. Row entries are read
// only where the counts say they were written, so the row RAM is never cleared.
`include "particle_pair_neighbor_table_macros.svh"
`default_nettype none
module particle_pair_neighbor_table #(
  parameter int PARTICLES = ppnt_pkg::PARTICLES_DEF,
  parameter int ROW_SLOTS = ppnt_pkg::ROW_SLOTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: first_particle[9:0], second_particle[19:10], slot[25:20], zero pad
  input  wire logic [ppnt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: mode[1:0]
  input  wire logic [ppnt_pkg::MODE_W-1:0]        in_tuser,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // out_tdata: neighbor[9:0], pair_ref[24:10], higher_count[31:25],
  //            lower_count[38:32], pair_total[54:39], zero pad
  output      logic [ppnt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: status[1:0]
  output      logic [ppnt_pkg::STATUS_W-1:0]      out_tuser,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready
);

  localparam int PW      = $clog2(PARTICLES);
  localparam int CW      = $clog2(ROW_SLOTS + 1);
  localparam int ENTRIES = PARTICLES * ROW_SLOTS;
  localparam int AW      = $clog2(ENTRIES);
  localparam int ROW_DW  = ppnt_pkg::NB_W + ppnt_pkg::REF_W;

  // Input field split
  logic [ppnt_pkg::PART_W-1:0] a_in, b_in, lo_in, hi_in;
  logic [ppnt_pkg::SLOT_W-1:0] slot_in;
  ppnt_pkg::mode_t             mode_in;

  assign a_in    = in_tdata[9:0];
  assign b_in    = in_tdata[19:10];
  assign slot_in = in_tdata[25:20];
  assign mode_in = ppnt_pkg::mode_t'(in_tuser);

  // Order the pair; a read uses the first particle as its row
  always_comb begin
    if (mode_in == ppnt_pkg::MODE_READ) begin
      lo_in = a_in;
      hi_in = a_in;
    end else if (a_in < b_in) begin
      lo_in = a_in;
      hi_in = b_in;
    end else begin
      lo_in = b_in;
      hi_in = a_in;
    end
  end

  // Registers
  ppnt_pkg::state_t            state_r, state_nxt;
  ppnt_pkg::mode_t             mode_r, mode_nxt;
  logic [ppnt_pkg::PART_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic                        lo_ok_r, lo_ok_nxt, hi_ok_r, hi_ok_nxt;
  logic [ppnt_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [AW-1:0]               base_lo_r, base_lo_nxt, base_hi_r, base_hi_nxt;
  logic [CW-1:0]               lf_r, lf_nxt, lb_r, lb_nxt, hf_r, hf_nxt, hb_r, hb_nxt;
  logic [ppnt_pkg::TOTAL_W-1:0] pair_cnt_r, pair_cnt_nxt;
  logic [PW-1:0]               clr_ptr_r, clr_ptr_nxt;
  logic                        init_r, init_nxt;
  ppnt_pkg::result_t           res_r, res_nxt, out_res_r, out_res_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Memory ports
  logic              cnt_we;
  logic [PW-1:0]     cnt_waddr, cnt_raddr;
  logic [2*CW-1:0]   cnt_wdata, cnt_rdata;
  logic              row_we;
  logic [AW-1:0]     row_waddr, row_raddr;
  logic [ROW_DW-1:0] row_wdata, row_rdata;

  logic [CW-1:0] hf_rd, hb_rd;
  logic          accept, full, used;

  assign in_tready = (state_r == ppnt_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign hf_rd     = cnt_rdata[CW-1:0];
  assign hb_rd     = cnt_rdata[2*CW-1:CW];

  // Count RAM: front count low, back count high
  ppnt_ram #(.DEPTH(PARTICLES), .WIDTH(2*CW)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Row RAM: neighbor low, pair number high
  ppnt_ram #(.DEPTH(ENTRIES), .WIDTH(ROW_DW)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // Count reads: lower row on accept, higher row after
  assign cnt_raddr = in_tready ? PW'(lo_in) : PW'(hi_r);
  assign row_raddr = base_lo_r + AW'(slot_r);

  // Overlap and pair number checks for an insert
  assign full = (32'(lf_r) + 32'(lb_r) + 32'd1 > 32'(ROW_SLOTS)) ||
                (32'(hf_rd) + 32'(hb_rd) + 32'd1 > 32'(ROW_SLOTS)) ||
                (pair_cnt_r >= ppnt_pkg::PAIR_REF_LIMIT);

  // Slot in use: inside the front part or the back part
  assign used = lo_ok_r && (32'(slot_r) < 32'(ROW_SLOTS)) &&
                ((32'(slot_r) < 32'(lf_r)) ||
                 (32'(slot_r) + 32'(lb_r) >= 32'(ROW_SLOTS)));

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lo_ok_nxt     = lo_ok_r;
    hi_ok_nxt     = hi_ok_r;
    slot_nxt      = slot_r;
    base_lo_nxt   = base_lo_r;
    base_hi_nxt   = base_hi_r;
    lf_nxt        = lf_r;
    lb_nxt        = lb_r;
    hf_nxt        = hf_r;
    hb_nxt        = hb_r;
    pair_cnt_nxt  = pair_cnt_r;
    clr_ptr_nxt   = clr_ptr_r;
    init_nxt      = init_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cnt_we        = 1'b0;
    cnt_waddr     = PW'(lo_r);
    cnt_wdata     = '0;
    row_we        = 1'b0;
    row_waddr     = base_lo_r + AW'(lf_r);
    row_wdata     = {pair_cnt_r[ppnt_pkg::REF_W-1:0], hi_r};

    case (state_r)
      ppnt_pkg::S_IDLE: begin
        if (accept) begin
          mode_nxt    = mode_in;
          lo_nxt      = lo_in;
          hi_nxt      = hi_in;
          lo_ok_nxt   = 32'(lo_in) < 32'(PARTICLES);
          hi_ok_nxt   = 32'(hi_in) < 32'(PARTICLES);
          slot_nxt    = slot_in;
          base_lo_nxt = AW'(32'(lo_in) * 32'(ROW_SLOTS));
          base_hi_nxt = AW'(32'(hi_in) * 32'(ROW_SLOTS));
          clr_ptr_nxt = '0;
          case (mode_in)
            ppnt_pkg::MODE_CLEAR:  state_nxt = ppnt_pkg::S_CLEAR;
            ppnt_pkg::MODE_INSERT: state_nxt = ppnt_pkg::S_LO;
            ppnt_pkg::MODE_READ:   state_nxt = ppnt_pkg::S_LO;
            default: begin
              res_nxt            = '0;
              res_nxt.pair_total = pair_cnt_r;
              state_nxt          = ppnt_pkg::S_FINISH;
            end
          endcase
        end
      end

      // Zero one count entry per cycle
      ppnt_pkg::S_CLEAR: begin
        cnt_we      = 1'b1;
        cnt_waddr   = clr_ptr_r;
        cnt_wdata   = '0;
        clr_ptr_nxt = clr_ptr_r + PW'(1);
        if (clr_ptr_r == PW'(PARTICLES - 1)) begin
          pair_cnt_nxt = '0;
          res_nxt      = '0;
          init_nxt     = 1'b0;
          state_nxt    = init_r ? ppnt_pkg::S_IDLE : ppnt_pkg::S_FINISH;
        end
      end

      // Lower row counts arrive; higher row read goes out
      ppnt_pkg::S_LO: begin
        lf_nxt    = cnt_rdata[CW-1:0];
        lb_nxt    = cnt_rdata[2*CW-1:CW];
        state_nxt = ppnt_pkg::S_HI;
      end

      ppnt_pkg::S_HI: begin
        res_nxt            = '0;
        res_nxt.pair_total = pair_cnt_r;
        state_nxt          = ppnt_pkg::S_FINISH;
        if (mode_r == ppnt_pkg::MODE_READ) begin
          if (lo_ok_r) begin
            res_nxt.higher_count = ppnt_pkg::COUNT_W'(lf_r);
            res_nxt.lower_count  = ppnt_pkg::COUNT_W'(lb_r);
          end
          if (used) begin
            res_nxt.neighbor = row_rdata[ppnt_pkg::NB_W-1:0];
            res_nxt.pair_ref = row_rdata[ROW_DW-1:ppnt_pkg::NB_W];
          end
        end else if (lo_r == hi_r) begin
          res_nxt.status = ppnt_pkg::STAT_SELF;
          if (lo_ok_r) begin
            res_nxt.higher_count = ppnt_pkg::COUNT_W'(lf_r);
            res_nxt.lower_count  = ppnt_pkg::COUNT_W'(lb_r);
          end
        end else if (!hi_ok_r) begin
          res_nxt.status = ppnt_pkg::STAT_FULL;
        end else if (full) begin
          res_nxt.status       = ppnt_pkg::STAT_FULL;
          res_nxt.higher_count = ppnt_pkg::COUNT_W'(lf_r);
          res_nxt.lower_count  = ppnt_pkg::COUNT_W'(hb_rd);
        end else begin
          // Front slot of the lower row
          cnt_we    = 1'b1;
          cnt_waddr = PW'(lo_r);
          cnt_wdata = {lb_r, lf_r + CW'(1)};
          row_we    = 1'b1;
          row_waddr = base_lo_r + AW'(lf_r);
          row_wdata = {pair_cnt_r[ppnt_pkg::REF_W-1:0], hi_r};
          hf_nxt    = hf_rd;
          hb_nxt    = hb_rd;
          state_nxt = ppnt_pkg::S_WR_HI;
        end
      end

      // Back slot of the higher row
      ppnt_pkg::S_WR_HI: begin
        cnt_we       = 1'b1;
        cnt_waddr    = PW'(hi_r);
        cnt_wdata    = {hb_r + CW'(1), hf_r};
        row_we       = 1'b1;
        row_waddr    = base_hi_r + AW'(32'(ROW_SLOTS) - 32'd1 - 32'(hb_r));
        row_wdata    = {pair_cnt_r[ppnt_pkg::REF_W-1:0], lo_r};
        pair_cnt_nxt = pair_cnt_r + ppnt_pkg::TOTAL_W'(1);
        res_nxt      = '0;
        res_nxt.higher_count = ppnt_pkg::COUNT_W'(lf_r + CW'(1));
        res_nxt.lower_count  = ppnt_pkg::COUNT_W'(hb_r + CW'(1));
        res_nxt.pair_total   = pair_cnt_r + ppnt_pkg::TOTAL_W'(1);
        state_nxt    = ppnt_pkg::S_FINISH;
      end

      // Hand the result to the output register once it is free
      ppnt_pkg::S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ppnt_pkg::S_IDLE;
        end
      end

      default: state_nxt = ppnt_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppnt_pkg::S_CLEAR;
      clr_ptr_r   <= '0;
      init_r      <= 1'b1;
      pair_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      init_r      <= init_nxt;
      pair_cnt_r  <= pair_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    lo_ok_r   <= lo_ok_nxt;
    hi_ok_r   <= hi_ok_nxt;
    slot_r    <= slot_nxt;
    base_lo_r <= base_lo_nxt;
    base_hi_r <= base_hi_nxt;
    lf_r      <= lf_nxt;
    lb_r      <= lb_nxt;
    hf_r      <= hf_nxt;
    hb_r      <= hb_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.pair_total, out_res_r.lower_count,
                       out_res_r.higher_count, out_res_r.pair_ref, out_res_r.neighbor};
  assign out_tuser  = out_res_r.status;

  // Checks
  `PPNT_ASSERT(a_pair_cnt_limit, clk, rst_n, pair_cnt_r <= ppnt_pkg::PAIR_REF_LIMIT)
  `PPNT_ASSERT(a_row_wr_has_ref, clk, rst_n, row_we |-> pair_cnt_r < ppnt_pkg::PAIR_REF_LIMIT)
  `PPNT_ASSERT(a_cnt_no_overlap, clk, rst_n, cnt_we |-> (32'(cnt_wdata[CW-1:0]) + 32'(cnt_wdata[2*CW-1:CW]) <= 32'(ROW_SLOTS)))
  `PPNT_ASSERT_ALWAYS(a_clear_blocks_in, clk, state_r == ppnt_pkg::S_CLEAR |-> !in_tready)
  `PPNT_ASSERT(a_out_from_finish, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ppnt_pkg::S_FINISH))

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the particle pair neighbor table stream block.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppnt_pkg::*;

  localparam int PARTS = PARTICLES_DEF;
  localparam int SLOTS = ROW_SLOTS_DEF;

  // One queued command; a drain marker holds the sender until all results are in
  typedef struct {
    mode_t             mode;
    logic [PART_W-1:0] first;
    logic [PART_W-1:0] second;
    logic [SLOT_W-1:0] slot;
    bit                drain;
  } txn_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]      in_tuser = MODE_NOP;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  txn_t    table_cmds[$];
  result_t awaited_results[$];
  txn_t    in_flight;
  int      send_gap = 0, send_calm = 0;
  int      recv_stall = 0, recv_calm = 0;
  int      mismatches = 0;
  int      results_seen = 0;

  // Shadow copy of the block's tables
  logic [COUNT_W-1:0] front_cnt [PARTS];
  logic [COUNT_W-1:0] back_cnt  [PARTS];
  logic [NB_W-1:0]    row_nb    [PARTS*SLOTS];
  logic [REF_W-1:0]   row_ref   [PARTS*SLOTS];
  int                 pairs_made = 0;

  particle_pair_neighbor_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #5 clk = ~clk;

  // Applies one command to the shadow tables and returns the result it should give
  function automatic result_t predict_table_result(txn_t t);
    result_t r;
    int lo, hi, lf, lb, hf, hb, fi, bi, a, s, hc, lc;
    r = '0;
    a = t.first;
    s = t.slot;
    lo = (t.first < t.second) ? t.first : t.second;
    hi = (t.first < t.second) ? t.second : t.first;
    case (t.mode)
      MODE_CLEAR: begin
        foreach (front_cnt[i]) front_cnt[i] = '0;
        foreach (back_cnt[i]) back_cnt[i] = '0;
        pairs_made = 0;
      end
      MODE_INSERT: begin
        if (lo == hi) begin
          r.status = STAT_SELF;
          r.higher_count = front_cnt[lo];
          r.lower_count = back_cnt[lo];
        end else begin
          lf = front_cnt[lo];
          lb = back_cnt[lo];
          hf = front_cnt[hi];
          hb = back_cnt[hi];
          // reject when either row would overlap or pair numbers ran out
          if (lf + lb + 1 > SLOTS || hf + hb + 1 > SLOTS ||
              pairs_made >= int'(PAIR_REF_LIMIT)) begin
            r.status = STAT_FULL;
          end else begin
            fi = lo * SLOTS + lf;
            bi = hi * SLOTS + (SLOTS - 1 - hb);
            row_nb[fi] = NB_W'(hi);
            row_ref[fi] = REF_W'(pairs_made);
            row_nb[bi] = NB_W'(lo);
            row_ref[bi] = REF_W'(pairs_made);
            front_cnt[lo] = COUNT_W'(lf + 1);
            back_cnt[hi] = COUNT_W'(hb + 1);
            pairs_made++;
          end
          r.higher_count = front_cnt[lo];
          r.lower_count = back_cnt[hi];
        end
      end
      MODE_READ: begin
        hc = front_cnt[a];
        lc = back_cnt[a];
        r.higher_count = COUNT_W'(hc);
        r.lower_count = COUNT_W'(lc);
        // slot is in use if inside the front part or the back part
        if (s < hc || s >= SLOTS - lc) begin
          r.neighbor = row_nb[a * SLOTS + s];
          r.pair_ref = row_ref[a * SLOTS + s];
        end
      end
      default: ;
    endcase
    r.pair_total = (t.mode == MODE_CLEAR) ? '0 : TOTAL_W'(pairs_made);
    return r;
  endfunction

  // Idle length: mostly none or short, a few long, with calm stretches
  function automatic int draw_idle(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(30, 200);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic queue_txn(mode_t m, int a, int b, int s);
    txn_t t;
    t.mode = m;
    t.first = PART_W'(a);
    t.second = PART_W'(b);
    t.slot = SLOT_W'(s);
    t.drain = 1'b0;
    table_cmds.insert(table_cmds.size(), t);
  endtask

  task automatic queue_drain();
    txn_t t;
    t.mode = MODE_NOP;
    t.first = '0;
    t.second = '0;
    t.slot = '0;
    t.drain = 1'b1;
    table_cmds.insert(table_cmds.size(), t);
  endtask

  task automatic note_mismatch(string what, int want, int got);
    if (mismatches < 10)
      $display("MISMATCH %s on result %0d: expected %0d, got %0d",
               what, results_seen, want, got);
    mismatches++;
  endtask

  // Input driver: predicts each accepted transaction, then loads the next one
  always @(posedge clk) begin
    txn_t t;
    logic vld;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= MODE_NOP;
    end else begin
      vld = in_tvalid;
      if (in_tvalid && in_tready) begin
        awaited_results.insert(awaited_results.size(), predict_table_result(in_flight));
        vld = 1'b0;
      end
      if (!vld) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (table_cmds.size() != 0) begin
          if (table_cmds[0].drain) begin
            if (awaited_results.size() == 0) table_cmds.delete(0);
          end else begin
            t = table_cmds.pop_front();
            in_flight = t;
            in_tdata <= {6'b0, t.slot, t.second, t.first};
            in_tuser <= t.mode;
            vld = 1'b1;
            send_gap = draw_idle(send_calm);
          end
        end
      end
      in_tvalid <= vld;
    end
  end

  // Output monitor: checks each result against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("result with no prediction waiting", -1, int'(out_tdata[9:0]));
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[9:0] !== want.neighbor)
            note_mismatch("neighbor", want.neighbor, out_tdata[9:0]);
          if (out_tdata[24:10] !== want.pair_ref)
            note_mismatch("pair_ref", want.pair_ref, out_tdata[24:10]);
          if (out_tdata[31:25] !== want.higher_count)
            note_mismatch("higher_count", want.higher_count, out_tdata[31:25]);
          if (out_tdata[38:32] !== want.lower_count)
            note_mismatch("lower_count", want.lower_count, out_tdata[38:32]);
          if (out_tdata[54:39] !== want.pair_total)
            note_mismatch("pair_total", want.pair_total, out_tdata[54:39]);
          if (out_tuser !== want.status)
            note_mismatch("status", want.status, out_tuser);
        end
        results_seen++;
        recv_stall = draw_idle(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int members[8];
    int nmem, n, roll, x, y, rand_items, a, b;
    rand_items = 0;

    // shadow counts start empty, as the block's do after reset
    foreach (front_cnt[i]) front_cnt[i] = '0;
    foreach (back_cnt[i]) back_cnt[i] = '0;

    // directed: empty rows, extreme particles, self pairs, every mode
    queue_txn(MODE_READ, 0, 0, 0);
    queue_txn(MODE_INSERT, 0, 1023, 0);
    queue_txn(MODE_INSERT, 1023, 0, 63);
    queue_txn(MODE_INSERT, 5, 5, 0);
    queue_txn(MODE_INSERT, 1023, 1023, 63);
    queue_txn(MODE_READ, 0, 0, 0);
    queue_txn(MODE_READ, 0, 0, 1);
    queue_txn(MODE_READ, 1023, 1023, 63);
    queue_txn(MODE_READ, 1023, 0, 62);
    queue_txn(MODE_READ, 0, 1023, 63);
    queue_txn(MODE_READ, 1023, 0, 0);
    queue_txn(MODE_NOP, 1023, 1023, 63);
    queue_txn(MODE_NOP, 0, 0, 0);
    queue_txn(MODE_CLEAR, 1023, 1023, 63);
    queue_txn(MODE_READ, 0, 0, 0);
    queue_txn(MODE_READ, 1023, 0, 63);
    queue_txn(MODE_INSERT, 1, 0, 0);
    queue_txn(MODE_INSERT, 682, 341, 42);
    queue_txn(MODE_READ, 341, 0, 0);
    queue_txn(MODE_READ, 682, 682, 63);
    queue_drain();

    // random: mostly pair bursts inside small particle clusters so rows fill up
    while (rand_items < 1450) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        nmem = $urandom_range(2, 8);
        for (int k = 0; k < nmem; k++) members[k] = $urandom_range(0, PARTS - 1);
        n = $urandom_range(20, 200);
        for (int k = 0; k < n; k++) begin
          roll = $urandom_range(0, 99);
          x = members[$urandom_range(0, nmem - 1)];
          y = members[$urandom_range(0, nmem - 1)];
          if (roll < 6)
            queue_txn(MODE_INSERT, x, x, $urandom_range(0, 63));
          else if (roll < 70)
            queue_txn(MODE_INSERT, x, y, $urandom_range(0, 63));
          else if (roll < 85)
            queue_txn(MODE_READ, x, $urandom_range(0, PARTS - 1), $urandom_range(0, 7));
          else
            queue_txn(MODE_READ, x, $urandom_range(0, PARTS - 1), $urandom_range(0, 63));
        end
        rand_items += n;
      end else if (roll < 87) begin
        // noise: any field value, no clears
        n = $urandom_range(5, 20);
        for (int k = 0; k < n; k++)
          queue_txn(mode_t'(MODE_W'($urandom_range(1, 3))), $urandom_range(0, PARTS - 1),
                    $urandom_range(0, PARTS - 1), $urandom_range(0, 63));
        rand_items += n;
      end else if (roll < 92) begin
        queue_txn(MODE_CLEAR, $urandom_range(0, PARTS - 1), $urandom_range(0, PARTS - 1),
                  $urandom_range(0, 63));
        rand_items++;
      end else begin
        queue_drain();
      end
    end

    // row filling: particle 0 fills from the front, the last particle from the back,
    // and particle 500 from both ends until the two parts meet
    queue_txn(MODE_CLEAR, 0, 0, 0);
    for (int d = 1; d <= SLOTS; d++) begin
      if ($urandom_range(0, 1)) queue_txn(MODE_INSERT, 0, d, $urandom_range(0, 63));
      else queue_txn(MODE_INSERT, d, 0, $urandom_range(0, 63));
      if ($urandom_range(0, 7) == 0)
        queue_txn(MODE_READ, 0, 0, $urandom_range(0, 63));
    end
    for (int d = 1; d <= SLOTS; d++) begin
      a = PARTS - 1;
      b = PARTS - 1 - d;
      if ($urandom_range(0, 1)) queue_txn(MODE_INSERT, a, b, $urandom_range(0, 63));
      else queue_txn(MODE_INSERT, b, a, $urandom_range(0, 63));
      if ($urandom_range(0, 7) == 0)
        queue_txn(MODE_READ, a, 0, $urandom_range(0, 63));
    end
    for (int d = 1; d <= SLOTS / 2; d++) begin
      queue_txn(MODE_INSERT, 500, 500 - d, $urandom_range(0, 63));
      queue_txn(MODE_INSERT, 500 + d, 500, $urandom_range(0, 63));
    end
    queue_txn(MODE_INSERT, 0, 500, 0);
    queue_txn(MODE_INSERT, 1023, 1022, 0);
    queue_txn(MODE_INSERT, 500, 600, 0);
    queue_txn(MODE_INSERT, 499, 501, 0);
    queue_txn(MODE_INSERT, 3, 3, 0);
    for (int k = 0; k < 16; k++)
      queue_txn(MODE_READ, $urandom_range(0, PARTS - 1), 0, $urandom_range(0, 63));
    for (int k = 0; k < 8; k++)
      queue_txn(MODE_READ, 500, 0, $urandom_range(0, 63));
    queue_txn(MODE_READ, 0, 0, 63);
    queue_txn(MODE_READ, 1023, 0, 0);
    queue_txn(MODE_CLEAR, 0, 0, 0);
    queue_txn(MODE_READ, 0, 0, 0);
    queue_txn(MODE_INSERT, 9, 2, 0);
    queue_txn(MODE_READ, 2, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (table_cmds.size() != 0 || in_tvalid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/ppnt_pkg.sv
rtl/ppnt_ram.sv
rtl/particle_pair_neighbor_table.sv
verif/tb_top.sv
